[sv/point_in_triangle_3d_test_assert.svh]
// Assertion macros used by the point-in-triangle test top level.
`ifndef POINT_IN_TRIANGLE_3D_TEST_ASSERT_SVH
`define POINT_IN_TRIANGLE_3D_TEST_ASSERT_SVH

// ante must be followed by cons in the same cycle
`define PIT3D_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// bad must never hold out of reset
`define PIT3D_ASSERT_NEVER(lbl, ck, rn, bad, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) !(bad)) \
        else $error(msg);

`endif

[sv/pit3d_pkg.sv]
// Shared types and constants for the point-in-triangle test.
package pit3d_pkg;

    localparam int PIT3D_COORD_BITS = 16;
    localparam int NUM_AXES         = 3;
    localparam int CFG_INDEX_BITS   = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CORNER_FIRST  = 2'd0,
        REG_CORNER_SECOND = 2'd1,
        REG_CORNER_THIRD  = 2'd2
    } cfg_reg_t;

    // axis dropped for the 2D projection
    typedef enum logic [1:0] {
        DROP_X,
        DROP_Y,
        DROP_Z
    } drop_t;

    typedef struct packed {
        logic degenerate;
        logic hit;
    } pit3d_res_t;

endpackage

[sv/pit3d_core.sv]
// Eight-stage pipeline: normal, axis choice, projected barycentric sign test.
module pit3d_core #(
    parameter int COORD_BITS = pit3d_pkg::PIT3D_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [COORD_BITS-1:0] corner_a [pit3d_pkg::NUM_AXES],
    input  logic signed [COORD_BITS-1:0] corner_b [pit3d_pkg::NUM_AXES],
    input  logic signed [COORD_BITS-1:0] corner_c [pit3d_pkg::NUM_AXES],
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] point [pit3d_pkg::NUM_AXES],
    input  logic                         quad,
    output logic                         res_valid,
    input  logic                         res_ready,
    output pit3d_pkg::pit3d_res_t        res
);

    localparam int AX     = pit3d_pkg::NUM_AXES;
    localparam int DW     = COORD_BITS + 1;   // coordinate difference
    localparam int PW     = 2 * DW;           // product of two differences
    localparam int NW     = PW + 1;           // difference of two products
    localparam int SW     = NW + 2;           // u + v - d
    localparam int STAGES = 8;

    logic [STAGES:1] vld_reg;
    logic [STAGES:1] en;

    // per-stage enable: a stage loads when empty or when the next one loads
    always_comb
    begin
        en[STAGES] = !vld_reg[STAGES] || res_ready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[1];
    assign res_valid = vld_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= in_valid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: differences ----------------
    logic signed [DW-1:0] d0_reg [AX];
    logic signed [DW-1:0] d1_reg [AX];
    logic signed [DW-1:0] e0_1_reg [AX];
    logic signed [DW-1:0] e1_1_reg [AX];
    logic signed [DW-1:0] w_1_reg [AX];
    logic                 q_1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < AX; i++)
            begin
                d0_reg[i]   <= DW'(corner_a[i]) - DW'(corner_c[i]);
                d1_reg[i]   <= DW'(corner_b[i]) - DW'(corner_c[i]);
                e0_1_reg[i] <= DW'(corner_c[i]) - DW'(corner_a[i]);
                e1_1_reg[i] <= DW'(corner_b[i]) - DW'(corner_a[i]);
                w_1_reg[i]  <= DW'(point[i]) - DW'(corner_a[i]);
            end
            q_1_reg <= quad;
        end
    end

    // ---------------- stage 2: normal partial products ----------------
    // index 2*i is the positive term of normal component i, 2*i+1 the negative
    logic signed [PW-1:0] np_reg [2*AX];
    logic signed [DW-1:0] e0_2_reg [AX];
    logic signed [DW-1:0] e1_2_reg [AX];
    logic signed [DW-1:0] w_2_reg [AX];
    logic                 q_2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            np_reg[0] <= PW'(d0_reg[1]) * PW'(d1_reg[2]);
            np_reg[1] <= PW'(d0_reg[2]) * PW'(d1_reg[1]);
            np_reg[2] <= PW'(d0_reg[2]) * PW'(d1_reg[0]);
            np_reg[3] <= PW'(d0_reg[0]) * PW'(d1_reg[2]);
            np_reg[4] <= PW'(d0_reg[0]) * PW'(d1_reg[1]);
            np_reg[5] <= PW'(d0_reg[1]) * PW'(d1_reg[0]);
            e0_2_reg  <= e0_1_reg;
            e1_2_reg  <= e1_1_reg;
            w_2_reg   <= w_1_reg;
            q_2_reg   <= q_1_reg;
        end
    end

    // ---------------- stage 3: normal components ----------------
    logic signed [NW-1:0] n_reg [AX];
    logic signed [DW-1:0] e0_3_reg [AX];
    logic signed [DW-1:0] e1_3_reg [AX];
    logic signed [DW-1:0] w_3_reg [AX];
    logic                 q_3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < AX; i++)
            begin
                n_reg[i] <= NW'(np_reg[2*i]) - NW'(np_reg[2*i+1]);
            end
            e0_3_reg <= e0_2_reg;
            e1_3_reg <= e1_2_reg;
            w_3_reg  <= w_2_reg;
            q_3_reg  <= q_2_reg;
        end
    end

    // ---------------- stage 4: magnitudes ----------------
    logic        [NW-1:0] mag_next [AX];
    logic        [NW-1:0] mag_reg [AX];
    logic signed [DW-1:0] e0_4_reg [AX];
    logic signed [DW-1:0] e1_4_reg [AX];
    logic signed [DW-1:0] w_4_reg [AX];
    logic                 q_4_reg;

    always_comb
    begin
        for (int i = 0; i < AX; i++)
        begin
            mag_next[i] = n_reg[i][NW-1] ? NW'(-n_reg[i]) : NW'(n_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            mag_reg  <= mag_next;
            e0_4_reg <= e0_3_reg;
            e1_4_reg <= e1_3_reg;
            w_4_reg  <= w_3_reg;
            q_4_reg  <= q_3_reg;
        end
    end

    // ---------------- stage 5: axis choice and projection ----------------
    pit3d_pkg::drop_t     drop;
    logic signed [DW-1:0] e0x_next, e0y_next, e1x_next, e1y_next, wx_next, wy_next;
    logic signed [DW-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg, wx_reg, wy_reg;
    logic                 q_5_reg;

    always_comb
    begin
        // ties fall toward the later axis
        if (mag_reg[0] > mag_reg[1] && mag_reg[0] > mag_reg[2])
        begin
            drop = pit3d_pkg::DROP_X;
        end
        else if (mag_reg[1] > mag_reg[2])
        begin
            drop = pit3d_pkg::DROP_Y;
        end
        else
        begin
            drop = pit3d_pkg::DROP_Z;
        end
    end

    always_comb
    begin
        case (drop)
            pit3d_pkg::DROP_X:
            begin
                e0x_next = e0_4_reg[1]; e0y_next = e0_4_reg[2];
                e1x_next = e1_4_reg[1]; e1y_next = e1_4_reg[2];
                wx_next  = w_4_reg[1];  wy_next  = w_4_reg[2];
            end
            pit3d_pkg::DROP_Y:
            begin
                e0x_next = e0_4_reg[0]; e0y_next = e0_4_reg[2];
                e1x_next = e1_4_reg[0]; e1y_next = e1_4_reg[2];
                wx_next  = w_4_reg[0];  wy_next  = w_4_reg[2];
            end
            default:
            begin
                e0x_next = e0_4_reg[0]; e0y_next = e0_4_reg[1];
                e1x_next = e1_4_reg[0]; e1y_next = e1_4_reg[1];
                wx_next  = w_4_reg[0];  wy_next  = w_4_reg[1];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            e0x_reg <= e0x_next;
            e0y_reg <= e0y_next;
            e1x_reg <= e1x_next;
            e1y_reg <= e1y_next;
            wx_reg  <= wx_next;
            wy_reg  <= wy_next;
            q_5_reg <= q_4_reg;
        end
    end

    // ---------------- stage 6: 2D cross product terms ----------------
    logic signed [PW-1:0] dp_reg, dn_reg, up_reg, un_reg, vp_reg, vn_reg;
    logic                 q_6_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            dp_reg  <= PW'(e0x_reg) * PW'(e1y_reg);
            dn_reg  <= PW'(e0y_reg) * PW'(e1x_reg);
            up_reg  <= PW'(wx_reg) * PW'(e1y_reg);
            un_reg  <= PW'(wy_reg) * PW'(e1x_reg);
            vp_reg  <= PW'(e0x_reg) * PW'(wy_reg);
            vn_reg  <= PW'(e0y_reg) * PW'(wx_reg);
            q_6_reg <= q_5_reg;
        end
    end

    // ---------------- stage 7: D, U, V ----------------
    logic signed [NW-1:0] dd_reg, uu_reg, vv_reg;
    logic                 q_7_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            dd_reg  <= NW'(dp_reg) - NW'(dn_reg);
            uu_reg  <= NW'(up_reg) - NW'(un_reg);
            vv_reg  <= NW'(vp_reg) - NW'(vn_reg);
            q_7_reg <= q_6_reg;
        end
    end

    // ---------------- stage 8: sign decision, output register ----------------
    logic signed [SW-1:0]  ss;
    logic                  d_zero, d_neg, u_ok, v_ok, s_ok;
    pit3d_pkg::pit3d_res_t res_next;
    pit3d_pkg::pit3d_res_t res_reg;

    always_comb
    begin
        ss     = SW'(uu_reg) + SW'(vv_reg) - SW'(dd_reg);
        d_zero = (dd_reg == '0);
        d_neg  = dd_reg[NW-1];
        // u = U/D > 0 and v = V/D > 0: nonzero with the sign of D
        u_ok   = (uu_reg != '0) && (uu_reg[NW-1] == d_neg);
        v_ok   = (vv_reg != '0) && (vv_reg[NW-1] == d_neg);
        // u + v < 1: U + V - D nonzero with the sign opposite to D
        s_ok   = (ss != '0) && (ss[SW-1] != d_neg);
        res_next.degenerate = d_zero;
        res_next.hit        = !d_zero && u_ok && v_ok && (q_7_reg || s_ok);
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[sv/point_in_triangle_3d_test.sv]
// Top level: strict 3D point-in-triangle test of a configured triangle; tuser drops u+v<1.
//
//  channel  | dir | payload (lsb first)                        | transfer when
//  ---------+-----+--------------------------------------------+---------------------------
//  s_axis   | in  | tdata: point_x, point_y, point_z; tuser: quadrant_mode | tvalid & tready
//  m_axis   | out | tdata: inside_res, degenerate              | tvalid & tready
//  cfg      | in  | cfg_index selects corner, cfg_data = x,y,z | cfg_we
//
// One point per cycle sustained while m_axis is not stalled; each point passes
// through the eight register stages of pit3d_core (differences, two multiply
// stages, normal/abs/compare stages, D/U/V subtraction, final sign decision in
// the output register).
// rst_n clears all valid bits and the corner registers to zero.
// Each stage holds its item while the stage after it is full and stalled;
// empty stages keep filling, so while a result waits, input is taken until all stages are full.
module point_in_triangle_3d_test #(
    parameter int COORD_BITS = pit3d_pkg::PIT3D_COORD_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_we,
    input  logic [pit3d_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [3*COORD_BITS-1:0]               cfg_data,
    // point stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,  // point_x, point_y, point_z
    input  logic [0:0]                            s_axis_tuser,  // quadrant_mode
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [7:0]                            m_axis_tdata   // inside_res, degenerate
);

    localparam int AX    = pit3d_pkg::NUM_AXES;
    localparam int CFG_W = 3 * COORD_BITS;

    // corner registers, z,y,x packed with x in the low bits
    logic [CFG_W-1:0] corner_first_reg;
    logic [CFG_W-1:0] corner_second_reg;
    logic [CFG_W-1:0] corner_third_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_first_reg  <= '0;
            corner_second_reg <= '0;
            corner_third_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pit3d_pkg::REG_CORNER_FIRST:  corner_first_reg  <= cfg_data;
                pit3d_pkg::REG_CORNER_SECOND: corner_second_reg <= cfg_data;
                pit3d_pkg::REG_CORNER_THIRD:  corner_third_reg  <= cfg_data;
                default: ;  // unused index: write dropped
            endcase
        end
    end

    // unpack corners and point into per-axis signed coordinates
    logic signed [COORD_BITS-1:0] corner_a [AX];
    logic signed [COORD_BITS-1:0] corner_b [AX];
    logic signed [COORD_BITS-1:0] corner_c [AX];
    logic signed [COORD_BITS-1:0] point    [AX];

    always_comb
    begin
        for (int i = 0; i < AX; i++)
        begin
            corner_a[i] = $signed(corner_first_reg[i*COORD_BITS +: COORD_BITS]);
            corner_b[i] = $signed(corner_second_reg[i*COORD_BITS +: COORD_BITS]);
            corner_c[i] = $signed(corner_third_reg[i*COORD_BITS +: COORD_BITS]);
            point[i]    = $signed(s_axis_tdata[i*COORD_BITS +: COORD_BITS]);
        end
    end

    pit3d_pkg::pit3d_res_t res;

    // The user must change the corner registers only while the pipeline is empty;
    // the block does not enforce this. Only stage 1 of the core reads them.
    pit3d_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .corner_a  (corner_a),
        .corner_b  (corner_b),
        .corner_c  (corner_c),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .point     (point),
        .quad      (s_axis_tuser[0]),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {6'b0, res.degenerate, res.hit};

    // ---------------- assertions ----------------
`include "point_in_triangle_3d_test_assert.svh"

    logic out_free;
    logic degen_hit;

    assign out_free  = !m_axis_tvalid || m_axis_tready;
    assign degen_hit = m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[1];

    // a degenerate triangle never reports a hit
    `PIT3D_ASSERT_NEVER(a_degen_not_inside, clk, rst_n, degen_hit, "degenerate hit")

    // with the output side free, the whole pipeline advances and takes input
    `PIT3D_ASSERT_IMPLY(a_ready_free, clk, rst_n, out_free, s_axis_tready, "input stalled")

endmodule
